/* rtl/h264aus_pkg.sv */
// h264aus_pkg: types, constants and nal type helpers for the access unit splitter
// no dependencies; used by h264_access_unit_splitter
`timescale 1ns / 1ps
`default_nettype none

package h264aus_pkg;

  localparam int unsigned WinLen = 6;
  localparam int unsigned SkipW  = 2;

  localparam logic [SkipW-1:0] SkipAfterSlice = SkipW'(3);

  localparam logic [7:0] NalTypeMask = 8'h1F;
  localparam logic [7:0] FirstMbBit  = 8'h80;
  localparam logic [4:0] NalSlice    = 5'h1;
  localparam logic [4:0] NalIdr      = 5'h5;
  localparam logic [4:0] NalSei      = 5'h6;
  localparam logic [4:0] NalSps      = 5'h7;
  localparam logic [4:0] NalPps      = 5'h8;

  typedef struct packed {
    logic [7:0] data_in;
    logic       flush;
  } in_req_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       out_valid;
    logic       unit_start;
  } out_res_t;

  function automatic logic [4:0] nal_type(input logic [7:0] nal);
    logic [7:0] masked;
    masked = nal & NalTypeMask;
    return masked[4:0];
  endfunction

  function automatic logic frame_slice(input logic [7:0] nal, input logic [7:0] nxt);
    logic [4:0] t;
    t = nal_type(nal);
    return ((t == NalSlice) || (t == NalIdr)) && ((nxt & FirstMbBit) != 8'h00);
  endfunction

  function automatic logic param_or_sei(input logic [7:0] nal);
    logic [4:0] t;
    t = nal_type(nal);
    return (t == NalSps) || (t == NalPps) || (t == NalSei);
  endfunction

endpackage

`default_nettype wire

/* rtl/h264_access_unit_splitter.sv */
// h264_access_unit_splitter: annex b byte stream access unit boundary marker
// depends on h264aus_pkg for request types, constants and nal type helpers
//
// usage: one byte request per accepted in_req_i (or a flush request that
// shifts an empty slot in). every accepted request gives exactly one result
// on out_res_o: the byte leaving the oldest of six window positions, its
// valid flag and a flag set on the first start code byte of a new access
// unit. a byte therefore reappears six requests after it went in; send six
// flush requests to drain the tail of a stream.
// the result of a request is shown in the cycle after acceptance, held in an
// output register. one request per cycle unless stalled; the start code
// compare and nal type decode sit between the window and the output register.
// stall: while the output register holds a result not taken, in_ready_o stays
// high only if out_ready_i takes that result in the same cycle.
// reset: window emptied, no slice seen, output register empty.
`timescale 1ns / 1ps
`default_nettype none

module h264_access_unit_splitter (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire h264aus_pkg::in_req_t  in_req_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output h264aus_pkg::out_res_t      out_res_o
);

  logic [7:0]                    win_q [h264aus_pkg::WinLen];
  logic [h264aus_pkg::WinLen-1:0] win_vld_q, win_vld_d;
  logic                          slice_seen_q, slice_seen_d;
  logic [h264aus_pkg::SkipW-1:0] skip_q, skip_d;
  logic                          res_vld_q;
  h264aus_pkg::out_res_t         res_q, res_d;

  logic       accept;
  logic       code3, code4, hit, is_slice, is_param, mark;
  logic [7:0] nal, nxt;

  assign in_ready_o  = !res_vld_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = res_vld_q;
  assign out_res_o   = res_q;

  // start code tests at the oldest position
  always_comb begin
    code3 = (win_q[0] == 8'h00) && (win_q[1] == 8'h00) && (win_q[2] == 8'h01);
    code4 = (win_q[0] == 8'h00) && (win_q[1] == 8'h00) && (win_q[2] == 8'h00)
            && (win_q[3] == 8'h01);
    nal   = code3 ? win_q[3] : win_q[4];
    nxt   = code3 ? win_q[4] : win_q[5];
    hit   = (skip_q == '0) && (&win_vld_q) && (code3 || code4);
    is_slice = hit && h264aus_pkg::frame_slice(nal, nxt);
    is_param = hit && h264aus_pkg::param_or_sei(nal);
    mark     = slice_seen_q && (is_slice || is_param);
  end

  always_comb begin
    slice_seen_d = slice_seen_q;
    if (is_slice) begin
      slice_seen_d = 1'b1;
    end else if (mark) begin
      slice_seen_d = 1'b0;
    end

    if (skip_q != '0) begin
      skip_d = skip_q - 1'b1;
    end else if (is_slice) begin
      skip_d = h264aus_pkg::SkipAfterSlice;
    end else begin
      skip_d = '0;
    end

    win_vld_d = {!in_req_i.flush, win_vld_q[h264aus_pkg::WinLen-1:1]};

    res_d.data_out   = win_vld_q[0] ? win_q[0] : 8'h00;
    res_d.out_valid  = win_vld_q[0];
    res_d.unit_start = win_vld_q[0] && mark;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q    <= '0;
      slice_seen_q <= 1'b0;
      skip_q       <= '0;
      res_vld_q    <= 1'b0;
    end else begin
      if (accept) begin
        win_vld_q    <= win_vld_d;
        slice_seen_q <= slice_seen_d;
        skip_q       <= skip_d;
        res_vld_q    <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q    <= 1'b0;
      end
    end
  end

  // window bytes and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < h264aus_pkg::WinLen - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[h264aus_pkg::WinLen-1] <= in_req_i.flush ? 8'h00 : in_req_i.data_in;
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire
